// ----- hw/rtl/slfr_pkg.sv -----
package slfr_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HUNT  = 3'd1;
  localparam logic [2:0] PH_SYNC2 = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_LENHI = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;
  localparam logic [2:0] PH_ERROR = 3'd6;

  localparam logic [7:0]  SYNC_A   = 8'h80;
  localparam logic [7:0]  SYNC_B   = 8'h81;
  localparam logic [7:0]  TRAILER  = 8'h82;
  localparam logic [3:0]  VER_HIGH = 4'h1;
  localparam logic [15:0] MIN_LEN  = 16'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ST_GOOD        = 2'd0;
  localparam logic [1:0] ST_VERSION_BAD = 2'd1;
  localparam logic [1:0] ST_TRAILER_BAD = 2'd2;

  localparam logic REG_USER_VERSION = 1'b0;
  localparam logic REG_LINK_ENABLED = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  frame_status;
    logic [15:0] payload_count;
  } result_t;

endpackage

// ----- hw/rtl/sync_length_frame_receiver.sv -----
// channel   | dir | handshake              | content
// s_axis    | in  | s_axis_tvalid/tready   | received byte, link fault flag
// m_axis    | out | m_axis_tvalid/tready   | data byte, end of frame, link error
// apb       | in  | psel/penable/pready    | user_version, link_enabled
//
// one byte per cycle: the parser decides each byte in the cycle it is taken
// and writes any result into a two-entry output buffer.
// s_axis_tready drops only while both buffer entries hold results.
// reset (rst_ni low, asynchronous) clears parser state, registers and buffer.
// the link error state is left only by reset.
module sync_length_frame_receiver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [slfr_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // rx_byte
  input  logic [slfr_pkg::IN_USER_W-1:0]     s_axis_tuser,  // link_fault
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // data_byte[7:0], frame_status[9:8], payload_count[25:10], zero[31:26]
  output logic [slfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic [slfr_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // kind
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [slfr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [slfr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [slfr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import slfr_pkg::*;

  logic [3:0]  user_version_q;
  logic        link_enabled_q;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] bytes_seen_q, bytes_seen_d;
  logic        version_match_q, version_match_d;

  logic        in_fire;
  logic [7:0]  rx_byte;
  logic        link_fault;
  logic        res_valid;
  result_t     res;
  logic [15:0] full_length;
  logic        more_body;

  result_t     head_q, tail_q;
  logic        head_valid_q, tail_valid_q;
  logic        pop, push;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_version_q <= '0;
      link_enabled_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_USER_VERSION: user_version_q <= pwdata[3:0];
        REG_LINK_ENABLED: link_enabled_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_USER_VERSION: prdata[3:0] = user_version_q;
      REG_LINK_ENABLED: prdata[0]   = link_enabled_q;
      default: ;
    endcase
  end

  // parser
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign rx_byte     = s_axis_tdata;
  assign link_fault  = s_axis_tuser[0];
  assign full_length = {rx_byte, frame_length_q[7:0]};
  assign more_body   = ({1'b0, bytes_seen_q} + 17'd1) < {1'b0, frame_length_q};

  always_comb begin
    phase_d         = phase_q;
    frame_length_d  = frame_length_q;
    bytes_seen_d    = bytes_seen_q;
    version_match_d = version_match_q;
    res_valid       = 1'b0;
    res             = '0;
    if (phase_q == PH_ERROR) begin
      phase_d = PH_ERROR;
    end else if (!link_enabled_q) begin
      phase_d = PH_IDLE;
    end else if (link_fault) begin
      phase_d   = PH_ERROR;
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
    end else begin
      case (phase_q)
        PH_SYNC2: begin
          phase_d = (rx_byte == SYNC_B) ? PH_LENLO : PH_HUNT;
        end
        PH_LENLO: begin
          frame_length_d = {8'h00, rx_byte};
          phase_d        = PH_LENHI;
        end
        PH_LENHI: begin
          frame_length_d  = full_length;
          bytes_seen_d    = '0;
          version_match_d = 1'b0;
          phase_d         = (full_length >= MIN_LEN) ? PH_BODY : PH_HUNT;
        end
        PH_BODY: begin
          bytes_seen_d = bytes_seen_q + 16'd1;
          if (bytes_seen_q == '0) begin
            version_match_d = (rx_byte == {VER_HIGH, user_version_q});
          end else if (more_body) begin
            if (version_match_q) begin
              res_valid     = 1'b1;
              res.kind      = KIND_DATA;
              res.data_byte = rx_byte;
            end
          end else begin
            phase_d           = PH_HUNT;
            res_valid         = 1'b1;
            res.kind          = KIND_END;
            res.payload_count = frame_length_q - 16'd2;
            if (rx_byte != TRAILER) begin
              res.frame_status = ST_TRAILER_BAD;
            end else if (!version_match_q) begin
              res.frame_status = ST_VERSION_BAD;
            end else begin
              res.frame_status = ST_GOOD;
            end
          end
        end
        default: begin
          phase_d = (rx_byte == SYNC_A) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      frame_length_q  <= '0;
      bytes_seen_q    <= '0;
      version_match_q <= 1'b0;
    end else if (in_fire) begin
      phase_q         <= phase_d;
      frame_length_q  <= frame_length_d;
      bytes_seen_q    <= bytes_seen_d;
      version_match_q <= version_match_d;
    end
  end

  // two-entry output buffer
  assign s_axis_tready = !tail_valid_q;
  assign pop           = head_valid_q && m_axis_tready;
  assign push          = in_fire && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      tail_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (tail_valid_q) begin
          tail_valid_q <= 1'b0;
        end else begin
          head_valid_q <= push;
        end
      end else if (push) begin
        if (head_valid_q) begin
          tail_valid_q <= 1'b1;
        end else begin
          head_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (tail_valid_q) begin
        head_q <= tail_q;
      end else if (push) begin
        head_q <= res;
      end
    end else if (push) begin
      if (head_valid_q) begin
        tail_q <= res;
      end else begin
        head_q <= res;
      end
    end
  end

  assign m_axis_tvalid = head_valid_q;
  assign m_axis_tuser  = head_q.kind;
  assign m_axis_tdata  = {6'd0, head_q.payload_count, head_q.frame_status, head_q.data_byte};

endmodule
